FILE: hdl/dgae_pkg.sv
// shared types and codes of the dueling gate amplitude engine
// used by dgae_weight and the top level; no dependencies
`default_nettype none

package dgae_pkg;

    localparam int MODE_W   = 2;
    localparam int IDX_W    = 6;
    localparam int COUNT_W  = 16;
    localparam int CTOTAL_W = 7;
    localparam int PROB_W   = 24;
    localparam int STATUS_W = 2;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INIT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GATE1 = 2'd2;
    localparam logic [MODE_W-1:0] MODE_GATE2 = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_SOL    = 2'd2;

    localparam logic REG_TOTAL_COUNT   = 1'b0;
    localparam logic REG_CLUSTER_TOTAL = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WEIGHT,
        ST_INIT_W,
        ST_INIT_WL,
        ST_I_RD,
        ST_I_MUL,
        ST_I_WR,
        ST_G_RD,
        ST_G_MUL,
        ST_G_ACC,
        ST_G_H,
        ST_U_RD,
        ST_U_MUL,
        ST_U_WR,
        ST_SCAN,
        ST_P_RD,
        ST_P_SQ,
        ST_P_ACC,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        WS_IDLE,
        WS_DIV,
        WS_SQRT,
        WS_DONE
    } t_wstate;

    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] total;
    } t_wt_req;

endpackage

`default_nettype wire

FILE: hdl/dgae_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module dgae_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/dgae_weight.sv
// cluster weight unit: sqrt(count / total) in fixed point, one bit per cycle
// restoring division followed by a digit-by-digit square root; uses dgae_pkg
`default_nettype none

module dgae_weight #(
    parameter int AMP_BITS = 24
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire dgae_pkg::t_wt_req i_req,
    output logic                  o_done,
    output logic [AMP_BITS-1:0]   o_weight
);

    localparam int F    = AMP_BITS - 2;
    localparam int CNW  = dgae_pkg::COUNT_W;
    localparam int DW   = CNW + 2 * F;
    localparam int VW   = 2 * F + 2;
    localparam int RW   = F + 4;
    localparam int CNTW = $clog2(DW + 1);

    dgae_pkg::t_wstate r_state, n_state;
    logic [CNTW-1:0]   r_cnt;
    logic [CNW:0]      r_rem;
    logic [DW-1:0]     r_dv;
    logic [DW-1:0]     r_q;
    logic [CNW-1:0]    r_tot;
    logic              r_sat;
    logic [VW-1:0]     r_sv;
    logic [RW-1:0]     r_srem;
    logic [F:0]        r_root;
    logic [AMP_BITS-1:0] r_weight;

    logic [CNW:0] rem_s;
    logic         ge;
    logic [RW-1:0] srem_s;
    logic [RW-1:0] trial;
    logic          sge;
    logic          div_last;
    logic          sqrt_last;

    assign rem_s     = {r_rem[CNW-1:0], r_dv[DW-1]};
    assign ge        = rem_s >= {1'b0, r_tot};
    assign srem_s    = {r_srem[RW-3:0], r_sv[VW-1:VW-2]};
    assign trial     = {1'b0, r_root, 2'b01};
    assign sge       = srem_s >= trial;
    assign div_last  = r_cnt == CNTW'(DW - 1);
    assign sqrt_last = r_cnt == CNTW'(F);

    always_comb begin
        n_state = r_state;
        case (r_state)
            dgae_pkg::WS_IDLE: begin
                if (i_req.start) n_state = dgae_pkg::WS_DIV;
            end
            dgae_pkg::WS_DIV: begin
                if (div_last) n_state = dgae_pkg::WS_SQRT;
            end
            dgae_pkg::WS_SQRT: begin
                if (sqrt_last) n_state = dgae_pkg::WS_DONE;
            end
            dgae_pkg::WS_DONE: n_state = dgae_pkg::WS_IDLE;
            default:           n_state = dgae_pkg::WS_IDLE;
        endcase
    end

    always_comb begin
        case (r_state)
            dgae_pkg::WS_DONE: o_done = 1'b1;
            default:           o_done = 1'b0;
        endcase
    end

    assign o_weight = r_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dgae_pkg::WS_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                dgae_pkg::WS_IDLE: begin
                    r_cnt <= '0;
                    r_rem <= '0;
                    r_q   <= '0;
                    r_dv  <= {i_req.count, {(2 * F){1'b0}}};
                    r_tot <= (i_req.total == '0) ? CNW'(1) : i_req.total;
                end
                dgae_pkg::WS_DIV: begin
                    r_rem <= ge ? rem_s - {1'b0, r_tot} : rem_s;
                    r_dv  <= r_dv << 1;
                    r_q   <= {r_q[DW-2:0], ge};
                    if (div_last) begin
                        r_cnt  <= '0;
                        // quotient of four or more saturates the weight
                        r_sat  <= |r_q[DW-2:VW-1];
                        r_sv   <= {r_q[VW-2:0], ge};
                        r_srem <= '0;
                        r_root <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                dgae_pkg::WS_SQRT: begin
                    r_srem <= sge ? srem_s - trial : srem_s;
                    r_root <= {r_root[F-1:0], sge};
                    r_sv   <= r_sv << 2;
                    r_cnt  <= r_cnt + 1'b1;
                    if (sqrt_last) begin
                        r_weight <= r_sat ? {1'b0, {(AMP_BITS - 1){1'b1}}}
                                          : {1'b0, r_root[F-1:0], sge};
                    end
                end
                default: begin
                    r_cnt <= '0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hdl/dueling_gate_amplitude_engine_unit.sv
// Dueling gate amplitude engine. Amplitudes sit in one ram of MAX_CLUSTERS^2
// entries (each side rounded up to a power of two), weights in a second ram;
// one item is worked at a time, and every matrix access goes through a read, a
// multiply and a write or accumulate step. With n clusters in use: a load
// runs the weight unit (one division bit and then one root bit a cycle); each
// gate makes a sum and an update pass over every entry; every item then scans
// up to n solution flags and sums the probability over the row and column of
// the first flagged one. The result sits in an output register, so the next
// item is taken while a result waits. Uses dgae_pkg, dgae_ram, dgae_weight.
`default_nettype none

module dueling_gate_amplitude_engine_unit #(
    parameter int MAX_CLUSTERS = 64,
    parameter int AMP_BITS     = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [dgae_pkg::MODE_W-1:0]   i_mode,
    input  wire logic [dgae_pkg::IDX_W-1:0]    i_cluster_index,
    input  wire logic [dgae_pkg::COUNT_W-1:0]  i_cluster_count,
    input  wire logic                          i_is_solution,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [dgae_pkg::PROB_W-1:0]        o_best_prob,
    output logic [dgae_pkg::STATUS_W-1:0]      o_status,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int F     = AMP_BITS - 2;
    localparam int IW    = $clog2(MAX_CLUSTERS);
    localparam int CW    = $clog2(MAX_CLUSTERS + 1);
    localparam int AAW   = 2 * IW;
    localparam int ADEP  = (1 << IW) * (1 << IW);
    localparam int PW    = AMP_BITS + 32;
    localparam int HW    = AMP_BITS + 10;
    localparam int VW    = 36;
    localparam int SQW   = 2 * AMP_BITS;
    localparam int PACCW = 34;
    localparam int SH    = 2 * F - 22;
    localparam int CNW   = dgae_pkg::COUNT_W;

    localparam longint AMP_MAX_L = (longint'(1) <<< (AMP_BITS - 1)) - 1;
    localparam longint AMP_MIN_L = -AMP_MAX_L - 1;
    localparam logic signed [PW-1:0] P_MAX  = PW'(AMP_MAX_L);
    localparam logic signed [PW-1:0] P_MIN  = PW'(AMP_MIN_L);
    localparam logic signed [PW-1:0] P_HALF = PW'(longint'(1) <<< (F - 1));
    localparam logic signed [VW-1:0] V_MAX  = VW'(AMP_MAX_L);
    localparam logic signed [VW-1:0] V_MIN  = VW'(AMP_MIN_L);
    localparam logic signed [63:0]   I32_MAX = 64'sd2147483647;
    localparam logic signed [63:0]   I32_MIN = -64'sd2147483648;
    localparam logic [PACCW-1:0]     PROB_MAX = PACCW'(24'hFFFFFF);

    // configuration
    logic [CNW-1:0]                  r_total;
    logic [dgae_pkg::CTOTAL_W-1:0]   r_ctotal;
    logic                            cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= CNW'(1);
            r_ctotal <= dgae_pkg::CTOTAL_W'(1);
        end else if (cfg_we) begin
            case (paddr[2])
                dgae_pkg::REG_TOTAL_COUNT:   r_total  <= pwdata[CNW-1:0];
                dgae_pkg::REG_CLUSTER_TOTAL: r_ctotal <= pwdata[dgae_pkg::CTOTAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            dgae_pkg::REG_TOTAL_COUNT:   prdata = {16'b0, r_total};
            dgae_pkg::REG_CLUSTER_TOTAL: prdata = {25'b0, r_ctotal};
            default:                     prdata = '0;
        endcase
    end

    // active dimension
    logic [8:0]    ct9, n9, idx9;
    logic [CW-1:0] n_act, last_n;

    assign ct9    = {2'b0, r_ctotal};
    assign n9     = (ct9 == 9'd0) ? 9'd1 :
                    ((ct9 > 9'(MAX_CLUSTERS)) ? 9'(MAX_CLUSTERS) : ct9);
    assign n_act  = n9[CW-1:0];
    assign last_n = n_act - 1'b1;
    assign idx9   = {3'b0, i_cluster_index};

    // sequencer registers
    dgae_pkg::t_state            r_state, n_state;
    logic [dgae_pkg::MODE_W-1:0] r_mode;
    logic                        r_bad;
    logic [IW-1:0]               r_idx;
    logic                        r_is_sol;
    logic [CW-1:0]               r_outer, r_inner;
    logic [IW-1:0]               r_sol;
    logic                        r_found;
    logic                        r_side;
    logic [MAX_CLUSTERS-1:0]     r_flag;
    logic [CNW-1:0]              r_count;
    logic                        r_wstart;

    // datapath registers
    logic signed [AMP_BITS-1:0] r_wo;
    logic signed [AMP_BITS-1:0] r_a;
    logic signed [PW-1:0]       r_prod;
    logic signed [HW-1:0]       r_h;
    logic signed [31:0]         r_rsum;
    logic [SQW-1:0]             r_sq;
    logic [PACCW-1:0]           r_pacc;

    // ram ports
    logic                   amp_we;
    logic [AAW-1:0]         amp_waddr, amp_raddr;
    logic [AMP_BITS-1:0]    amp_wdata, amp_rdata;
    logic                   wt_we;
    logic [IW-1:0]          wt_raddr;
    logic [AMP_BITS-1:0]    wt_rdata;

    dgae_pkg::t_wt_req      wt_req;
    logic                   wt_done;
    logic [AMP_BITS-1:0]    wt_value;

    dgae_ram #(.WIDTH(AMP_BITS), .DEPTH(ADEP)) u_amp_ram (
        .i_clk   (i_clk),
        .i_we    (amp_we),
        .i_waddr (amp_waddr),
        .i_wdata (amp_wdata),
        .i_raddr (amp_raddr),
        .o_rdata (amp_rdata)
    );

    dgae_ram #(.WIDTH(AMP_BITS), .DEPTH(MAX_CLUSTERS)) u_wt_ram (
        .i_clk   (i_clk),
        .i_we    (wt_we),
        .i_waddr (r_idx),
        .i_wdata (wt_value),
        .i_raddr (wt_raddr),
        .o_rdata (wt_rdata)
    );

    assign wt_req.start = r_wstart;
    assign wt_req.count = r_count;
    assign wt_req.total = r_total;

    dgae_weight #(.AMP_BITS(AMP_BITS)) u_weight (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (wt_req),
        .o_done   (wt_done),
        .o_weight (wt_value)
    );

    // arithmetic
    logic                        accept;
    logic                        in_last, out_last;
    logic                        sg_neg;
    logic [IW-1:0]               in_i, out_i;
    logic [AAW-1:0]              gate_addr, prob_addr;
    logic signed [SQW-1:0]       mul_i, mul_g;
    logic signed [PW-1:0]        mul_u;
    logic signed [PW-1:0]        rnd_p;
    logic signed [AMP_BITS-1:0]  init_val;
    logic signed [HW-1:0]        term;
    logic signed [63:0]          h64;
    logic signed [31:0]          h_sat;
    logic signed [VW-1:0]        v_raw;
    logic signed [AMP_BITS-1:0]  upd_val;
    logic [AMP_BITS-1:0]         mag;
    logic [PACCW-1:0]            sqr;
    logic [PACCW-1:0]            prob_sat;

    assign accept    = i_in_valid && !o_in_stall;
    assign in_last   = r_inner == last_n;
    assign out_last  = r_outer == last_n;
    assign in_i      = r_inner[IW-1:0];
    assign out_i     = r_outer[IW-1:0];
    // sign rule taken with the inner index as the first argument
    assign sg_neg    = (r_inner < r_outer) && r_flag[in_i];
    assign gate_addr = (r_mode == dgae_pkg::MODE_GATE1) ? {in_i, out_i} : {out_i, in_i};
    assign prob_addr = r_side ? {in_i, r_sol} : {r_sol, in_i};

    assign mul_i = r_wo * $signed(wt_rdata);
    assign mul_g = $signed(wt_rdata) * $signed(amp_rdata);
    assign mul_u = $signed(wt_rdata) * r_rsum;
    // half up rounding is a floor shift after adding one half
    assign rnd_p = (r_prod + P_HALF) >>> F;

    assign init_val = (rnd_p > P_MAX) ? AMP_BITS'(AMP_MAX_L) :
                      ((rnd_p < P_MIN) ? AMP_BITS'(AMP_MIN_L) : rnd_p[AMP_BITS-1:0]);

    assign term  = sg_neg ? -rnd_p[HW-1:0] : rnd_p[HW-1:0];
    assign h64   = 64'(r_h);
    assign h_sat = (h64 > I32_MAX) ? 32'sh7FFFFFFF :
                   ((h64 < I32_MIN) ? 32'sh80000000 : h64[31:0]);

    assign v_raw   = (rnd_p[VW-1:0] <<< 1) + (sg_neg ? VW'(r_a) : -VW'(r_a));
    assign upd_val = (v_raw > V_MAX) ? AMP_BITS'(AMP_MAX_L) :
                     ((v_raw < V_MIN) ? AMP_BITS'(AMP_MIN_L) : v_raw[AMP_BITS-1:0]);

    assign mag = amp_rdata[AMP_BITS-1] ? -amp_rdata : amp_rdata;

    generate
        if (SH > 0) begin : g_sq_down
            logic [SQW:0] sq_r;
            assign sq_r = {1'b0, r_sq} + (SQW + 1)'(longint'(1) <<< (SH - 1));
            assign sqr  = PACCW'(sq_r >> SH);
        end else begin : g_sq_up
            assign sqr = PACCW'(r_sq) << (-SH);
        end
    endgenerate

    assign prob_sat = (r_pacc > PROB_MAX) ? PROB_MAX : r_pacc;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dgae_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_mode)
                        dgae_pkg::MODE_LOAD:
                            n_state = (idx9 >= n9) ? dgae_pkg::ST_SCAN : dgae_pkg::ST_WEIGHT;
                        dgae_pkg::MODE_INIT: n_state = dgae_pkg::ST_INIT_W;
                        default:             n_state = dgae_pkg::ST_G_RD;
                    endcase
                end
            end
            dgae_pkg::ST_WEIGHT:  if (wt_done) n_state = dgae_pkg::ST_SCAN;
            dgae_pkg::ST_INIT_W:  n_state = dgae_pkg::ST_INIT_WL;
            dgae_pkg::ST_INIT_WL: n_state = dgae_pkg::ST_I_RD;
            dgae_pkg::ST_I_RD:    n_state = dgae_pkg::ST_I_MUL;
            dgae_pkg::ST_I_MUL:   n_state = dgae_pkg::ST_I_WR;
            dgae_pkg::ST_I_WR: begin
                if (!in_last)      n_state = dgae_pkg::ST_I_RD;
                else if (out_last) n_state = dgae_pkg::ST_SCAN;
                else               n_state = dgae_pkg::ST_INIT_W;
            end
            dgae_pkg::ST_G_RD:  n_state = dgae_pkg::ST_G_MUL;
            dgae_pkg::ST_G_MUL: n_state = dgae_pkg::ST_G_ACC;
            dgae_pkg::ST_G_ACC: n_state = in_last ? dgae_pkg::ST_G_H : dgae_pkg::ST_G_RD;
            dgae_pkg::ST_G_H:   n_state = dgae_pkg::ST_U_RD;
            dgae_pkg::ST_U_RD:  n_state = dgae_pkg::ST_U_MUL;
            dgae_pkg::ST_U_MUL: n_state = dgae_pkg::ST_U_WR;
            dgae_pkg::ST_U_WR: begin
                if (!in_last)      n_state = dgae_pkg::ST_U_RD;
                else if (out_last) n_state = dgae_pkg::ST_SCAN;
                else               n_state = dgae_pkg::ST_G_RD;
            end
            dgae_pkg::ST_SCAN: begin
                if (r_flag[in_i])  n_state = dgae_pkg::ST_P_RD;
                else if (in_last)  n_state = dgae_pkg::ST_DONE;
            end
            dgae_pkg::ST_P_RD: n_state = dgae_pkg::ST_P_SQ;
            dgae_pkg::ST_P_SQ: n_state = dgae_pkg::ST_P_ACC;
            dgae_pkg::ST_P_ACC: begin
                if ((!r_side && r_inner != CW'(r_sol)) || !in_last)
                    n_state = dgae_pkg::ST_P_RD;
                else
                    n_state = dgae_pkg::ST_DONE;
            end
            dgae_pkg::ST_DONE: begin
                if (!(o_out_valid && i_out_stall)) n_state = dgae_pkg::ST_IDLE;
            end
            default: n_state = dgae_pkg::ST_IDLE;
        endcase
    end

    // ram controls
    always_comb begin
        amp_we    = 1'b0;
        amp_waddr = gate_addr;
        amp_wdata = upd_val;
        amp_raddr = gate_addr;
        wt_we     = 1'b0;
        wt_raddr  = in_i;
        o_in_stall = 1'b1;
        case (r_state)
            dgae_pkg::ST_IDLE:   o_in_stall = 1'b0;
            dgae_pkg::ST_WEIGHT: wt_we = wt_done;
            dgae_pkg::ST_INIT_W: wt_raddr = out_i;
            dgae_pkg::ST_I_WR: begin
                amp_we    = 1'b1;
                amp_waddr = {out_i, in_i};
                amp_wdata = init_val;
            end
            dgae_pkg::ST_U_WR:   amp_we = 1'b1;
            dgae_pkg::ST_P_RD:   amp_raddr = prob_addr;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dgae_pkg::ST_IDLE;
            r_flag      <= '0;
            r_outer     <= '0;
            r_inner     <= '0;
            r_side      <= 1'b0;
            r_found     <= 1'b0;
            r_wstart    <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wstart <= 1'b0;
            // the done state loads the next result itself
            if (o_out_valid && !i_out_stall && r_state != dgae_pkg::ST_DONE)
                o_out_valid <= 1'b0;
            case (r_state)
                dgae_pkg::ST_IDLE: begin
                    r_outer <= '0;
                    r_inner <= '0;
                    r_side  <= 1'b0;
                    r_found <= 1'b0;
                    r_h     <= '0;
                    r_pacc  <= '0;
                    if (accept) begin
                        r_mode   <= i_mode;
                        r_bad    <= (i_mode == dgae_pkg::MODE_LOAD) && (idx9 >= n9);
                        r_idx    <= idx9[IW-1:0];
                        r_is_sol <= i_is_solution;
                        r_count  <= i_cluster_count;
                        r_wstart <= (i_mode == dgae_pkg::MODE_LOAD) && (idx9 < n9);
                    end
                end
                dgae_pkg::ST_WEIGHT: begin
                    if (wt_done) r_flag[r_idx] <= r_is_sol;
                end
                dgae_pkg::ST_INIT_WL: r_wo <= $signed(wt_rdata);
                dgae_pkg::ST_I_MUL:   r_prod <= PW'(mul_i);
                dgae_pkg::ST_I_WR: begin
                    if (in_last) begin
                        r_inner <= '0;
                        r_outer <= r_outer + 1'b1;
                    end else begin
                        r_inner <= r_inner + 1'b1;
                    end
                end
                dgae_pkg::ST_G_MUL: r_prod <= PW'(mul_g);
                dgae_pkg::ST_G_ACC: begin
                    r_h     <= r_h + term;
                    r_inner <= in_last ? '0 : r_inner + 1'b1;
                end
                dgae_pkg::ST_G_H: r_rsum <= h_sat;
                dgae_pkg::ST_U_MUL: begin
                    r_prod <= mul_u;
                    r_a    <= $signed(amp_rdata);
                end
                dgae_pkg::ST_U_WR: begin
                    if (in_last) begin
                        r_inner <= '0;
                        r_outer <= r_outer + 1'b1;
                        r_h     <= '0;
                    end else begin
                        r_inner <= r_inner + 1'b1;
                    end
                end
                dgae_pkg::ST_SCAN: begin
                    if (r_flag[in_i]) begin
                        r_sol   <= in_i;
                        r_found <= 1'b1;
                        r_inner <= '0;
                        r_side  <= 1'b0;
                    end else begin
                        r_inner <= r_inner + 1'b1;
                    end
                end
                dgae_pkg::ST_P_SQ: r_sq <= SQW'(mag) * SQW'(mag);
                dgae_pkg::ST_P_ACC: begin
                    r_pacc <= r_pacc + sqr;
                    // the diagonal entry is counted once
                    if (!r_side && r_inner != CW'(r_sol)) begin
                        r_side <= 1'b1;
                    end else begin
                        r_side  <= 1'b0;
                        r_inner <= r_inner + 1'b1;
                    end
                end
                dgae_pkg::ST_DONE: begin
                    if (!(o_out_valid && i_out_stall)) begin
                        o_out_valid <= 1'b1;
                        o_best_prob <= r_found ? prob_sat[dgae_pkg::PROB_W-1:0] : '0;
                        o_status    <= r_bad   ? dgae_pkg::STATUS_BAD_INDEX :
                                       (r_found ? dgae_pkg::STATUS_OK
                                                : dgae_pkg::STATUS_NO_SOL);
                    end
                end
                default: ;
            endcase
        end
    end

    // an accepted item always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != dgae_pkg::ST_IDLE)
        else $error("accepted transfer did not start work");

    // a new result is loaded only from the done state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == dgae_pkg::ST_DONE)
        else $error("result loaded outside done state");

    // amplitude writes stay inside the active matrix
    a_amp_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        amp_we |-> (r_outer < n_act && r_inner < n_act))
        else $error("amplitude write outside active dimension");

    // probability reads only for a flagged cluster
    a_sol_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dgae_pkg::ST_P_RD |-> r_found && r_flag[r_sol])
        else $error("probability sum on a cluster that is not a solution");

endmodule

`default_nettype wire

FILE: tb/dueling_gate_amplitude_engine_unit_tb.sv
// self-checking testbench for the dueling gate amplitude engine: directed table, then random
// phases over several register settings, results checked by an in-bench predictor or table
// depends on dgae_pkg and dueling_gate_amplitude_engine_unit
`default_nettype none

module dueling_gate_amplitude_engine_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     NCL      = 64;
    localparam int     FRAC     = 22;
    localparam longint AMP_MAX  = (longint'(1) << 23) - 1;
    localparam longint AMP_MIN  = -(longint'(1) << 23);
    localparam longint SUM_MAX  = 64'sh7FFF_FFFF;
    localparam longint SUM_MIN  = -64'sh8000_0000;
    localparam longint PROB_SAT = 16777215;

    typedef struct {
        logic [dgae_pkg::MODE_W-1:0]   mode;
        logic [dgae_pkg::IDX_W-1:0]    idx;
        logic [dgae_pkg::COUNT_W-1:0]  cnt;
        logic                          sol;
        bit                            has_exp;
        logic [dgae_pkg::PROB_W-1:0]   xprob;
        logic [dgae_pkg::STATUS_W-1:0] xstat;
    } t_item;

    typedef struct {
        logic [dgae_pkg::PROB_W-1:0]   prob;
        logic [dgae_pkg::STATUS_W-1:0] status;
    } t_result;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic [dgae_pkg::MODE_W-1:0]     mode;
    logic [dgae_pkg::IDX_W-1:0]      cluster_index;
    logic [dgae_pkg::COUNT_W-1:0]    cluster_count;
    logic                            is_solution;
    logic                            out_valid;
    logic                            out_stall;
    logic [dgae_pkg::PROB_W-1:0]     best_prob;
    logic [dgae_pkg::STATUS_W-1:0]   status;
    logic                            psel, penable, pwrite, pready;
    logic [2:0]                      paddr;
    logic [31:0]                     pwdata, prdata;

    dueling_gate_amplitude_engine_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_mode(mode), .i_cluster_index(cluster_index),
        .i_cluster_count(cluster_count), .i_is_solution(is_solution),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_best_prob(best_prob), .o_status(status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    longint amp_mx [NCL*NCL];
    longint wt     [NCL];
    bit     sol_fl [NCL];
    longint reflect;
    int     cfg_total;
    int     cfg_clusters;

    t_result pending_q[$];
    t_item   table_q[$];
    int      errors, n_in, n_out, n_gates, n_phases;
    int      burst_left;
    bit      hold_req;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic longint rnd22(longint x);
        return (x + (longint'(1) << (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic longint clampv(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic int eff_n();
        if (cfg_clusters == 0) return 1;
        if (cfg_clusters > NCL) return NCL;
        return cfg_clusters;
    endfunction

    function automatic longint sign_of(int a, int b);
        return (a < b && sol_fl[a]) ? -1 : 1;
    endfunction

    // floor(sqrt(count/total) * 2^22) by long division then bitwise root, saturated to AMP_MAX
    function automatic longint cluster_weight(longint cnt, longint tot);
        longint q, rem, r, bv, v;
        if (tot == 0) tot = 1;
        q   = cnt / tot;
        rem = cnt % tot;
        if (q >= 4) return AMP_MAX;
        for (int i = 0; i < 2*FRAC; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= tot) begin
                rem = rem - tot;
                q   = q | 1;
            end
        end
        v  = q;
        r  = 0;
        bv = longint'(1) << 62;
        while (bv > v) bv = bv >> 2;
        while (bv != 0) begin
            if (v >= r + bv) begin
                v = v - (r + bv);
                r = (r >> 1) + bv;
            end else begin
                r = r >> 1;
            end
            bv = bv >> 2;
        end
        return r > AMP_MAX ? AMP_MAX : r;
    endfunction

    function automatic longint sq22(longint a);
        longint m;
        m = a < 0 ? -a : a;
        return (m*m + (longint'(1) << 21)) >> 22;
    endfunction

    function automatic t_result amp_step(t_item it);
        t_result res;
        int      n, s;
        bit      bad;
        longint  h, v, sum;
        n   = eff_n();
        bad = 1'b0;
        case (it.mode)
            dgae_pkg::MODE_LOAD: begin
                if (it.idx >= n) begin
                    bad = 1'b1;
                end else begin
                    wt[it.idx]     = cluster_weight(it.cnt, cfg_total);
                    sol_fl[it.idx] = it.sol;
                end
            end
            dgae_pkg::MODE_INIT: begin
                for (int k = 0; k < n; k++)
                    for (int l = 0; l < n; l++)
                        amp_mx[k*NCL+l] = clampv(rnd22(wt[k]*wt[l]), AMP_MIN, AMP_MAX);
            end
            dgae_pkg::MODE_GATE1: begin
                for (int l = 0; l < n; l++) begin
                    h = 0;
                    for (int j = 0; j < n; j++)
                        h += sign_of(j, l) * rnd22(wt[j]*amp_mx[j*NCL+l]);
                    reflect = clampv(h, SUM_MIN, SUM_MAX);
                    for (int k = 0; k < n; k++) begin
                        v = 2*rnd22(wt[k]*reflect) - sign_of(k, l)*amp_mx[k*NCL+l];
                        amp_mx[k*NCL+l] = clampv(v, AMP_MIN, AMP_MAX);
                    end
                end
            end
            default: begin
                for (int k = 0; k < n; k++) begin
                    h = 0;
                    for (int j = 0; j < n; j++)
                        h += sign_of(j, k) * rnd22(wt[j]*amp_mx[k*NCL+j]);
                    reflect = clampv(h, SUM_MIN, SUM_MAX);
                    for (int l = 0; l < n; l++) begin
                        v = 2*rnd22(wt[l]*reflect) - sign_of(l, k)*amp_mx[k*NCL+l];
                        amp_mx[k*NCL+l] = clampv(v, AMP_MIN, AMP_MAX);
                    end
                end
            end
        endcase
        // probability of the lowest flagged cluster: its row plus its column
        s = 0;
        while (s < n && !sol_fl[s]) s++;
        sum = 0;
        if (s < n) begin
            for (int i = 0; i < n; i++) begin
                sum += sq22(amp_mx[s*NCL+i]);
                if (i != s) sum += sq22(amp_mx[i*NCL+s]);
            end
        end
        res.prob   = sum > PROB_SAT ? PROB_SAT[dgae_pkg::PROB_W-1:0]
                                    : sum[dgae_pkg::PROB_W-1:0];
        res.status = bad ? dgae_pkg::STATUS_BAD_INDEX :
                     (s < n ? dgae_pkg::STATUS_OK : dgae_pkg::STATUS_NO_SOL);
        return res;
    endfunction

    function automatic t_item mk(logic [dgae_pkg::MODE_W-1:0] m, int idx, int cnt, bit sol);
        t_item it;
        it.mode    = m;
        it.idx     = idx[dgae_pkg::IDX_W-1:0];
        it.cnt     = cnt[dgae_pkg::COUNT_W-1:0];
        it.sol     = sol;
        it.has_exp = 1'b0;
        it.xprob   = '0;
        it.xstat   = dgae_pkg::STATUS_OK;
        return it;
    endfunction

    function automatic t_item mk_x(t_item it, int p, logic [dgae_pkg::STATUS_W-1:0] st);
        it.has_exp = 1'b1;
        it.xprob   = p[dgae_pkg::PROB_W-1:0];
        it.xstat   = st;
        return it;
    endfunction

    function automatic t_item rand_item();
        t_item it;
        int    n, r, v;
        n = eff_n();
        r = $urandom_range(0, 99);
        // big matrices make gates slow, so keep those mostly to loads
        if (n >= 32)
            it.mode = r < 85 ? dgae_pkg::MODE_LOAD :
                      (r < 90 ? dgae_pkg::MODE_INIT :
                       (r < 95 ? dgae_pkg::MODE_GATE1 : dgae_pkg::MODE_GATE2));
        else
            it.mode = r < 45 ? dgae_pkg::MODE_LOAD :
                      (r < 60 ? dgae_pkg::MODE_INIT :
                       (r < 80 ? dgae_pkg::MODE_GATE1 : dgae_pkg::MODE_GATE2));
        v = ($urandom_range(0, 99) < 85) ? $urandom_range(0, n-1) : $urandom_range(0, 63);
        it.idx = v[dgae_pkg::IDX_W-1:0];
        r = $urandom_range(0, 19);
        v = r == 0 ? 0 : (r == 1 ? 65535 : $urandom_range(0, 65535));
        it.cnt = v[dgae_pkg::COUNT_W-1:0];
        it.sol = $urandom_range(0, 99) < 35;
        it.has_exp = 1'b0;
        return it;
    endfunction

    task automatic send(t_item it);
        int gap;
        t_result r;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_valid      <= 1'b1;
        mode          <= it.mode;
        cluster_index <= it.idx;
        cluster_count <= it.cnt;
        is_solution   <= it.sol;
        do @(posedge i_clk); while (in_stall);
        r = amp_step(it);
        if (it.has_exp) begin
            r.prob   = it.xprob;
            r.status = it.xstat;
        end
        pending_q.push_back(r);
        n_in++;
        if (it.mode == dgae_pkg::MODE_GATE1 || it.mode == dgae_pkg::MODE_GATE2) n_gates++;
    endtask

    task automatic drain();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic reg_write(logic sel, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (sel == dgae_pkg::REG_TOTAL_COUNT) cfg_total = value & 16'hFFFF;
        else cfg_clusters = value & 7'h7F;
    endtask

    task automatic set_phase(int tot, int ncl);
        drain();
        reg_write(dgae_pkg::REG_TOTAL_COUNT, tot);
        reg_write(dgae_pkg::REG_CLUSTER_TOTAL, ncl);
        n_phases++;
    endtask

    // result side: checks transfers and drives its own stall pattern
    initial begin
        int  cyc, hold;
        bit  st;
        t_result e;
        out_stall <= 1'b0;
        cyc  = 0;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (out_valid && !out_stall) begin
                n_out++;
                if (pending_q.size() == 0) begin
                    $error("unexpected result transfer: best_prob %0d status %0d",
                           best_prob, status);
                    errors++;
                end else begin
                    e = pending_q.pop_front();
                    if (best_prob !== e.prob) begin
                        $error("best_prob: expected %0d, got %0d", e.prob, best_prob);
                        errors++;
                    end
                    if (status !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, status);
                        errors++;
                    end
                end
            end
            cyc++;
            if (hold > 0) begin
                hold--;
                st = 1'b1;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold     = 400;
                st       = 1'b1;
            end else begin
                case ((cyc / 64) % 4)
                    0: st = 1'b0;
                    1: st = $urandom_range(0, 3) == 0;
                    2: st = $urandom_range(0, 1) == 1;
                    default: st = cyc[0];
                endcase
            end
            out_stall <= st;
        end
    end

    initial begin
        in_valid      <= 1'b0;
        mode          <= dgae_pkg::MODE_LOAD;
        cluster_index <= '0;
        cluster_count <= '0;
        is_solution   <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_rst_n       <= 1'b0;
        errors = 0; n_in = 0; n_out = 0; n_gates = 0; n_phases = 0;
        burst_left = 0;
        hold_req   = 1'b0;
        reflect    = 0;
        cfg_total  = 1;
        cfg_clusters = 1;
        for (int i = 0; i < NCL; i++) begin
            wt[i]     = 0;
            sol_fl[i] = 1'b0;
        end
        for (int i = 0; i < NCL*NCL; i++) amp_mx[i] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single cluster after reset: unit weight, bad index, saturated and zero weight
        table_q.push_back(mk_x(mk(dgae_pkg::MODE_LOAD, 0, 1, 0), 0, dgae_pkg::STATUS_NO_SOL));
        table_q.push_back(mk_x(mk(dgae_pkg::MODE_LOAD, 63, 1, 1), 0,
                               dgae_pkg::STATUS_BAD_INDEX));
        table_q.push_back(mk_x(mk(dgae_pkg::MODE_INIT, 0, 0, 0), 0, dgae_pkg::STATUS_NO_SOL));
        table_q.push_back(mk_x(mk(dgae_pkg::MODE_LOAD, 0, 1, 1), 4194304, dgae_pkg::STATUS_OK));
        table_q.push_back(mk(dgae_pkg::MODE_GATE1, 0, 0, 0));
        table_q.push_back(mk(dgae_pkg::MODE_GATE2, 0, 0, 0));
        table_q.push_back(mk(dgae_pkg::MODE_LOAD, 0, 65535, 1));
        table_q.push_back(mk(dgae_pkg::MODE_INIT, 0, 0, 0));
        table_q.push_back(mk_x(mk(dgae_pkg::MODE_LOAD, 0, 0, 0), 0, dgae_pkg::STATUS_NO_SOL));
        foreach (table_q[i]) send(table_q[i]);

        // widest matrix: write every weight, then every amplitude, before any flag is set
        set_phase(65535, 64);
        for (int i = 0; i < NCL; i++)
            send(mk(dgae_pkg::MODE_LOAD, i,
                    i == 0 ? 65535 : (i == 1 ? 1 : $urandom_range(0, 65535)), 0));
        send(mk(dgae_pkg::MODE_INIT, 0, 0, 0));
        table_q.delete();
        table_q.push_back(mk(dgae_pkg::MODE_LOAD, 3, 65535, 1));
        table_q.push_back(mk(dgae_pkg::MODE_GATE1, 0, 0, 0));
        table_q.push_back(mk(dgae_pkg::MODE_GATE2, 0, 0, 0));
        table_q.push_back(mk(dgae_pkg::MODE_LOAD, 0, 20000, 1));
        table_q.push_back(mk(dgae_pkg::MODE_GATE1, 0, 0, 0));
        table_q.push_back(mk(dgae_pkg::MODE_LOAD, 63, 1, 1));
        foreach (table_q[i]) send(table_q[i]);

        // random phases, zero and oversized register values among them
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: set_phase(0, 0);
                1: set_phase(300, 2);
                2: set_phase(5000, 5);
                3: set_phase(1000, 127);
                4: set_phase(65535, 8);
                5: set_phase(1, 3);
                6: set_phase(40000, 16);
                default: set_phase($urandom_range(1, 65535), $urandom_range(1, 12));
            endcase
            if (p == 2) hold_req = 1'b1;
            for (int i = 0; i < 4; i++) begin
                if (p == 5 && i == 2) drain();
                send(rand_item());
            end
        end
        drain();
        repeat (100) @(posedge i_clk);

        $display("covered %0d transfers in, %0d results, %0d gate passes over %0d settings",
                 n_in, n_out, n_gates, n_phases);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
hdl/dgae_pkg.sv
hdl/dgae_ram.sv
hdl/dgae_weight.sv
hdl/dueling_gate_amplitude_engine_unit.sv
tb/dueling_gate_amplitude_engine_unit_tb.sv
